FILE: src/ufd_pkg.sv
`default_nettype none
package ufd_pkg;

  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [7:0]  HDR_BYTE  = 8'hBB;
  localparam logic [7:0]  END_BYTE  = 8'h7E;
  localparam logic [15:0] MIN_FRAME = 16'd7;

  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] MAX_LEN_RST = 16'd128;
  localparam logic [15:0] TIMEOUT_RST = 16'd40;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADEND = 3'd1,
    ST_BADSUM = 3'd2,
    ST_OVF    = 3'd3,
    ST_TMO    = 3'd4
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [7:0]  ftype;
    logic [7:0]  cmd;
    logic [15:0] len;
    status_e     status;
  } res_t;

endpackage
`default_nettype wire

FILE: src/ufd_req_if.sv
`default_nettype none
interface ufd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: src/ufd_res_if.sv
`default_nettype none
interface ufd_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  frame_type;
  logic [7:0]  command_code;
  logic [15:0] payload_len;
  logic [2:0]  frame_status;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output frame_type, output command_code,
                  output payload_len, output frame_status, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, input frame_type, input command_code,
                  input payload_len, input frame_status, output ready);
endinterface
`default_nettype wire

FILE: src/uhf_reader_frame_deframer_core.sv
`default_nettype none
// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+------------------------------------------
// req_i    | in  | valid/ready     | req_type, rx_byte
// res_o    | out | valid/ready     | result_kind, payload_byte, payload_index,
//          |     |                 | frame_type, command_code, payload_len,
//          |     |                 | frame_status
// cfg      | in  | cfg_we_i        | cfg_idx_i, cfg_data_i
//
// One beat is taken per cycle while req_i.ready is high; the frame state
// advances in that same cycle; a result is registered into the output or skid.
// A two-entry output buffer (output register plus skid) lets input beats keep
// flowing while a result waits; req_i.ready drops only when both are full.
// Reset puts the parser in header hunt with max_frame_len 128, timeout 40.
module uhf_reader_frame_deframer_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ufd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [ufd_pkg::CfgW-1:0]      cfg_data_i,
  ufd_req_if.sink                      req_i,
  ufd_res_if.source                    res_o
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_CMD     = 3'd2;
  localparam logic [2:0] PH_LENHI   = 3'd3;
  localparam logic [2:0] PH_LENLO   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CSUM    = 3'd6;
  localparam logic [2:0] PH_END     = 3'd7;

  logic [15:0] max_len_q, timeout_q;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        sum_ok_q, sum_ok_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic            out_vld_q, skid_vld_q;
  ufd_pkg::res_t   out_q, skid_q, res;
  logic            gen;
  logic            do_clear;
  logic            in_acc, out_take;

  logic [16:0] count;
  logic [15:0] cap;
  logic [15:0] idx;
  logic [16:0] idx_p1;
  logic [15:0] elapsed_inc;
  logic [15:0] len_lo;
  logic [7:0]  b;

  assign req_i.ready = !skid_vld_q;
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_take    = out_vld_q && res_o.ready;

  assign b           = req_i.rx_byte;
  assign count       = {1'b0, byte_cnt_q} + 17'd1;
  assign cap         = (max_len_q < ufd_pkg::MIN_FRAME) ? ufd_pkg::MIN_FRAME : max_len_q;
  assign idx         = 16'(count - 17'd6);
  assign idx_p1      = {1'b0, idx} + 17'd1;
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign len_lo      = {len_q[15:8], b};

  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    len_d      = len_q;
    sum_d      = sum_q;
    type_d     = type_q;
    cmd_d      = cmd_q;
    sum_ok_d   = sum_ok_q;
    elapsed_d  = elapsed_q;
    gen        = 1'b0;
    do_clear   = 1'b0;
    res        = '{kind: 1'b1, data: 8'd0, idx: 16'd0, ftype: type_q, cmd: cmd_q,
                   len: len_q, status: ufd_pkg::ST_OK};

    if (req_i.req_type) begin
      // tick: only counts once a header has been seen
      if (phase_q != PH_HUNT) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= timeout_q) begin
          gen        = 1'b1;
          do_clear   = 1'b1;
          res.status = ufd_pkg::ST_TMO;
        end
      end
    end else if (phase_q == PH_HUNT) begin
      if (b == ufd_pkg::HDR_BYTE) begin
        phase_d    = PH_TYPE;
        byte_cnt_d = 16'd1;
      end
    end else if (phase_q == PH_END) begin
      gen      = 1'b1;
      do_clear = 1'b1;
      if (b != ufd_pkg::END_BYTE) begin
        res.status = ufd_pkg::ST_BADEND;
      end else begin
        res.status = sum_ok_q ? ufd_pkg::ST_OK : ufd_pkg::ST_BADSUM;
      end
    end else if (count >= {1'b0, cap}) begin
      gen        = 1'b1;
      do_clear   = 1'b1;
      res.status = ufd_pkg::ST_OVF;
    end else begin
      byte_cnt_d = count[15:0];
      sum_d      = sum_q + b;
      unique case (phase_q)
        PH_TYPE: begin
          type_d  = b;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = b;
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d   = {b, 8'd0};
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          len_d   = len_lo;
          phase_d = (len_lo == 16'd0) ? PH_CSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (idx_p1 >= {1'b0, len_q}) begin
            phase_d = PH_CSUM;
          end
          gen      = 1'b1;
          res.kind = 1'b0;
          res.data = b;
          res.idx  = idx;
        end
        default: begin
          // checksum byte: no sum update
          sum_d    = sum_q;
          sum_ok_d = (sum_q == b);
          phase_d  = PH_END;
        end
      endcase
    end

    if (do_clear) begin
      phase_d    = PH_HUNT;
      byte_cnt_d = '0;
      len_d      = '0;
      sum_d      = '0;
      type_d     = '0;
      cmd_d      = '0;
      sum_ok_d   = 1'b0;
      elapsed_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ufd_pkg::MAX_LEN_RST;
      timeout_q <= ufd_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ufd_pkg::CFG_MAX_LEN) begin
        max_len_q <= cfg_data_i;
      end else if (cfg_idx_i == ufd_pkg::CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      byte_cnt_q <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      type_q     <= '0;
      cmd_q      <= '0;
      sum_ok_q   <= 1'b0;
      elapsed_q  <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      type_q     <= type_d;
      cmd_q      <= cmd_d;
      sum_ok_q   <= sum_ok_d;
      elapsed_q  <= elapsed_d;
    end
  end

  // output register plus skid: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc && gen) begin
      if (out_vld_q && !out_take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register plus skid: payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc && gen) begin
      if (out_vld_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.result_kind   = out_q.kind;
  assign res_o.payload_byte  = out_q.data;
  assign res_o.payload_index = out_q.idx;
  assign res_o.frame_type    = out_q.ftype;
  assign res_o.command_code  = out_q.cmd;
  assign res_o.payload_len   = out_q.len;
  assign res_o.frame_status  = out_q.status;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && gen && out_vld_q && !res_o.ready |=> skid_vld_q)
    else $error("result dropped while output stalled");

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> (byte_cnt_q == 16'd0 && elapsed_q == 16'd0))
    else $error("frame state not cleared while hunting");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.result_kind |-> res_o.frame_status == ufd_pkg::ST_OK)
    else $error("payload beat carries a non-ok status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_status <= ufd_pkg::ST_TMO)
    else $error("frame status out of range");

endmodule
`default_nettype wire
